@@ rtl/iso8601_duration_to_seconds_assert.svh @@
// Assertion macros shared by the duration parser modules.
`ifndef ISO8601_DURATION_TO_SECONDS_ASSERT_SVH
`define ISO8601_DURATION_TO_SECONDS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IDTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("idts assertion failed");

// Next-cycle implication, checked outside reset.
`define IDTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("idts assertion failed");

`endif

@@ rtl/idts_pkg.sv @@
// Shared types, constants and helpers for the ISO 8601 duration parser.
package idts_pkg;

    localparam int unsigned MAX_TOKEN_LEN = 255;
    localparam int unsigned COMPONENT_MAX = 65535;
    localparam int unsigned COMP_W        = 16;
    localparam int unsigned LEN_W         = 8;
    localparam int unsigned NUM_COMP      = 6;
    localparam int unsigned WEIGHT_W      = 25;
    localparam int unsigned PROD_W        = COMP_W + WEIGHT_W;
    localparam int unsigned SEC_W         = 42;
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Designator slot codes within the date or time part.
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_NONE   = 2'd3;

    // Seconds per unit: Y, M, D, H, M, S (index 0 = years).
    localparam logic [NUM_COMP-1:0][WEIGHT_W-1:0] WEIGHT = {
        25'd1, 25'd60, 25'd3600, 25'd86400, 25'd2592000, 25'd31536000
    };

    typedef enum logic [2:0] {
        PH_AWAIT_P,
        PH_DATE,
        PH_TIME,
        PH_STOP,
        PH_FAIL
    } phase_t;

    // One finished token, handed from the parser to the arithmetic side.
    typedef struct packed {
        logic                              started;
        logic [LEN_W-1:0]                  clen;
        logic                              sat;
        logic [NUM_COMP-1:0][COMP_W-1:0]   comp;
    } tok_rec_t;

    function automatic logic [1:0] designator_slot(input logic [7:0] ch,
                                                   input logic       time_part);
        logic [1:0] slot;
        slot = SLOT_NONE;
        if (!time_part) begin
            if (ch == CH_Y) slot = SLOT_FIRST;
            if (ch == CH_M) slot = SLOT_SECOND;
            if (ch == CH_D) slot = SLOT_THIRD;
        end else begin
            if (ch == CH_H) slot = SLOT_FIRST;
            if (ch == CH_M) slot = SLOT_SECOND;
            if (ch == CH_S) slot = SLOT_THIRD;
        end
        return slot;
    endfunction

endpackage

@@ rtl/iso8601_duration_to_seconds.sv @@
// Top level of the ISO 8601 duration-to-seconds stream parser.
// Usage:
//   Slave side takes one token character per item: s_tdata is the ASCII code,
//   s_tlast marks the final character of the token. Each token yields exactly
//   one result item on the master side, at its last character.
//   The result gives accepted (token began with P and a closed group is
//   nonzero), the consumed length through the last closed group, T or P,
//   a saturation flag for any digit group clamped at 65535, and total seconds
//   with 365-day years and 30-day months.
// Timing:
//   One character per cycle while the queue has room. The parser computes its
//   state update combinationally (compare, times-ten accumulate); a four-entry
//   record queue decouples it from a four-register multiply/add pipeline of
//   product, pair-sum, partial-total and output registers.
// Reset:
//   aresetn low (synchronous) returns the parser to awaiting P and empties
//   the queue and the pipeline.
// Stalls:
//   While a result waits with m_tready low it holds and the pipeline stops; the queue
//   then absorbs up to four finished tokens before s_tready drops.
module iso8601_duration_to_seconds (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [8:1] consumed_length, [9] component_saturated,
    // [51:10] duration_seconds, [55:52] zero
    output logic [55:0] m_tdata
);
    import idts_pkg::*;

    logic     push, full, pop, nonempty;
    tok_rec_t push_rec, pop_rec;

    idts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_rec    (push_rec)
    );

    idts_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .pop_rec  (pop_rec)
    );

    idts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (nonempty),
        .q_rec      (pop_rec),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );
endmodule

@@ rtl/idts_front.sv @@
// Character parser: walks the token one item per cycle while the queue has room, emits one record per token.
`include "iso8601_duration_to_seconds_assert.svh"
module idts_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             q_push,
    output idts_pkg::tok_rec_t q_rec
);
    import idts_pkg::*;

    phase_t                          phase_reg, phase_next;
    logic [1:0]                      ndi_reg, ndi_next;
    logic [COMP_W-1:0]               acc_reg, acc_next;
    logic                            pend_reg, pend_next;
    logic [LEN_W-1:0]                pos_reg, pos_next;
    logic [LEN_W-1:0]                clen_reg, clen_next;
    logic [NUM_COMP-1:0][COMP_W-1:0] comp_reg, comp_next;
    logic                            sat_reg, sat_next;
    logic                            take;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_AWAIT_P;
            ndi_reg   <= '0;
            acc_reg   <= '0;
            pend_reg  <= 1'b0;
            pos_reg   <= '0;
            clen_reg  <= '0;
            comp_reg  <= '0;
            sat_reg   <= 1'b0;
        end else if (take) begin
            if (s_tlast) begin
                phase_reg <= PH_AWAIT_P;
                ndi_reg   <= '0;
                acc_reg   <= '0;
                pend_reg  <= 1'b0;
                pos_reg   <= '0;
                clen_reg  <= '0;
                comp_reg  <= '0;
                sat_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                ndi_reg   <= ndi_next;
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                pos_reg   <= pos_next;
                clen_reg  <= clen_next;
                comp_reg  <= comp_next;
                sat_reg   <= sat_next;
            end
        end
    end

    always_comb begin
        logic [19:0]         acc_wide;
        logic [1:0]          slot;
        logic [2:0]          idx;
        logic                time_part;
        logic [LEN_W-1:0]    pos_inc;

        phase_next = phase_reg;
        ndi_next   = ndi_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        clen_next  = clen_reg;
        comp_next  = comp_reg;
        sat_next   = sat_reg;
        pos_inc    = pos_reg + 1'b1;
        time_part  = (phase_reg == PH_TIME);
        acc_wide   = 20'(acc_reg) * 20'd10 + 20'(s_tdata[3:0]);
        slot       = designator_slot(s_tdata, time_part);
        idx        = time_part ? (3'd3 + 3'(slot)) : 3'(slot);

        unique case (phase_reg) inside
            PH_STOP, PH_FAIL: begin
            end
            default: begin
                if (32'(pos_reg) >= MAX_TOKEN_LEN) begin
                    // token too long: stop where we are
                    phase_next = (phase_reg == PH_AWAIT_P) ? PH_FAIL : PH_STOP;
                end else begin
                    pos_next = pos_inc;
                    if (phase_reg == PH_AWAIT_P) begin
                        if (s_tdata == CH_P) begin
                            phase_next = PH_DATE;
                            clen_next  = pos_inc;
                        end else begin
                            phase_next = PH_FAIL;
                        end
                    end else if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
                        if (32'(acc_wide) > COMPONENT_MAX) begin
                            acc_next = COMP_W'(COMPONENT_MAX);
                            sat_next = 1'b1;
                        end else begin
                            acc_next = acc_wide[COMP_W-1:0];
                        end
                        pend_next = 1'b1;
                    end else if (pend_reg) begin
                        if (slot != SLOT_NONE && slot >= ndi_reg) begin
                            comp_next[idx] = acc_reg;
                            ndi_next       = slot + 1'b1;
                            clen_next      = pos_inc;
                            acc_next       = '0;
                            pend_next      = 1'b0;
                        end else begin
                            phase_next = PH_STOP;
                        end
                    end else if (!time_part && s_tdata == CH_T) begin
                        phase_next = PH_TIME;
                        ndi_next   = '0;
                        clen_next  = pos_inc;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
            end
        endcase
    end

    assign q_push        = take && s_tlast;
    assign q_rec.started = (phase_next != PH_AWAIT_P) && (phase_next != PH_FAIL);
    assign q_rec.clen    = clen_next;
    assign q_rec.sat     = sat_next;
    assign q_rec.comp    = comp_next;

    `IDTS_ASSERT_NEXT(a_front_rearm, aclk, aresetn, take && s_tlast,
                      phase_reg == PH_AWAIT_P && pos_reg == '0 && comp_reg == '0)
    `IDTS_ASSERT_NOW(a_front_pos_bound, aclk, aresetn, 1'b1,
                     32'(pos_reg) <= MAX_TOKEN_LEN)
endmodule

@@ rtl/idts_fifo.sv @@
// Short record queue between the parser and the arithmetic pipeline.
`include "iso8601_duration_to_seconds_assert.svh"
module idts_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  idts_pkg::tok_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output idts_pkg::tok_rec_t pop_rec
);
    import idts_pkg::*;

    tok_rec_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign pop_rec  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `IDTS_ASSERT_NOW(a_fifo_no_overrun, aclk, aresetn, push, !full)
    `IDTS_ASSERT_NOW(a_fifo_count_bound, aclk, aresetn, 1'b1,
                     count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
endmodule

@@ rtl/idts_back.sv @@
// Weighted-sum pipeline: unit multiplies, adder tree, output register.
`include "iso8601_duration_to_seconds_assert.svh"
module idts_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_nonempty,
    input  idts_pkg::tok_rec_t q_rec,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata
);
    import idts_pkg::*;

    logic                              adv;
    // stage 1: products
    logic                              v1_reg;
    logic [NUM_COMP-1:0][PROD_W-1:0]   prod_reg;
    logic                              ok1_reg, sat1_reg;
    logic [LEN_W-1:0]                  len1_reg;
    // stage 2: pair sums
    logic                              v2_reg;
    logic [2:0][SEC_W-1:0]             pair_reg;
    logic                              ok2_reg, sat2_reg;
    logic [LEN_W-1:0]                  len2_reg;
    // stage 3: partial total
    logic                              v3_reg;
    logic [SEC_W-1:0]                  part_reg, rest_reg;
    logic                              ok3_reg, sat3_reg;
    logic [LEN_W-1:0]                  len3_reg;
    // output register
    logic                              vo_reg;
    logic                              acc_o_reg, sat_o_reg;
    logic [LEN_W-1:0]                  len_o_reg;
    logic [SEC_W-1:0]                  sec_o_reg;

    // The whole pipe moves together whenever the output slot is free or draining.
    assign adv   = !vo_reg || m_tready;
    assign q_pop = adv && q_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_nonempty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                prod_reg[i] <= PROD_W'(q_rec.comp[i]) * PROD_W'(WEIGHT[i]);
            end
            ok1_reg  <= q_rec.started && (q_rec.comp != '0);
            sat1_reg <= q_rec.sat;
            len1_reg <= q_rec.clen;

            for (int j = 0; j < 3; j++) begin
                pair_reg[j] <= SEC_W'(prod_reg[2*j]) + SEC_W'(prod_reg[2*j+1]);
            end
            ok2_reg  <= ok1_reg;
            sat2_reg <= sat1_reg;
            len2_reg <= len1_reg;

            part_reg <= pair_reg[0] + pair_reg[1];
            rest_reg <= pair_reg[2];
            ok3_reg  <= ok2_reg;
            sat3_reg <= sat2_reg;
            len3_reg <= len2_reg;

            // max total is about 2.2e12, so 42 bits never overflow
            acc_o_reg <= ok3_reg;
            sat_o_reg <= sat3_reg;
            len_o_reg <= ok3_reg ? len3_reg : '0;
            sec_o_reg <= ok3_reg ? (part_reg + rest_reg) : '0;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {4'b0, sec_o_reg, sat_o_reg, len_o_reg, acc_o_reg};

    `IDTS_ASSERT_NEXT(a_back_deliver, aclk, aresetn, v3_reg && adv, vo_reg)
    `IDTS_ASSERT_NOW(a_back_reject_zero, aclk, aresetn, vo_reg && !acc_o_reg,
                     sec_o_reg == '0 && len_o_reg == '0)
endmodule

@@ sim/tb_iso8601_duration_to_seconds.sv @@
// Testbench for the ISO 8601 duration parser: directed and random tokens, scoreboard check.
module tb_iso8601_duration_to_seconds;
    import idts_pkg::*;

    localparam int          NUM_CHARS    = 1450;
    localparam logic [63:0] SECONDS_CAP  = 64'd4398046511103;
    localparam longint unsigned UNIT_SECS [6] = '{64'd31536000, 64'd2592000, 64'd86400,
                                                 64'd3600, 64'd60, 64'd1};

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } char_item_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  clen;
        logic        sat;
        logic [41:0] secs;
    } duration_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    char_item_t  pending_chars[$];
    duration_t   expected_durations[$];
    logic [7:0]  tok[$];

    // scoreboard bookkeeping
    int errors         = 0;
    int chars_sent     = 0;
    int tokens_done    = 0;
    int accepted_seen  = 0;
    int saturated_seen = 0;
    int quiet_from     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit char_taken     = 1'b0;

    // parser shadow state
    phase_t      ph        = PH_AWAIT_P;
    logic [1:0]  next_slot = SLOT_FIRST;
    int unsigned digit_acc = 0;
    bit          pend      = 1'b0;
    int unsigned pos_cnt   = 0;
    int unsigned committed = 0;
    int unsigned comp[6]   = '{default: 0};
    bit          sat_flag  = 1'b0;

    iso8601_duration_to_seconds dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Advance the shadow parser by one character; on the last one, queue the result.
    task automatic parse_char(input logic [7:0] c, input logic is_last);
        logic [1:0]  slot;
        bit          tpart;
        bit          any;
        int unsigned v;
        logic [63:0] total;
        duration_t   r;
        if (ph != PH_STOP && ph != PH_FAIL) begin
            if (pos_cnt >= MAX_TOKEN_LEN) begin
                ph = (ph == PH_AWAIT_P) ? PH_FAIL : PH_STOP;
            end else begin
                pos_cnt++;
                if (ph == PH_AWAIT_P) begin
                    if (c == CH_P) begin
                        ph = PH_DATE;
                        committed = pos_cnt;
                    end else begin
                        ph = PH_FAIL;
                    end
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    v = digit_acc * 10 + (c - CH_ZERO);
                    if (v > COMPONENT_MAX) begin
                        v = COMPONENT_MAX;
                        sat_flag = 1'b1;
                    end
                    digit_acc = v;
                    pend = 1'b1;
                end else begin
                    tpart = (ph == PH_TIME);
                    slot = SLOT_NONE;
                    case (c)
                        CH_Y: if (!tpart) slot = SLOT_FIRST;
                        CH_M: slot = SLOT_SECOND;
                        CH_D: if (!tpart) slot = SLOT_THIRD;
                        CH_H: if (tpart) slot = SLOT_FIRST;
                        CH_S: if (tpart) slot = SLOT_THIRD;
                        default: ;
                    endcase
                    if (pend) begin
                        // a group closes only on a designator not yet passed
                        if (slot != SLOT_NONE && slot >= next_slot) begin
                            comp[(tpart ? 3 : 0) + slot] = digit_acc;
                            next_slot = slot + 2'd1;
                            committed = pos_cnt;
                            digit_acc = 0;
                            pend = 1'b0;
                        end else begin
                            ph = PH_STOP;
                        end
                    end else if (!tpart && c == CH_T) begin
                        ph = PH_TIME;
                        next_slot = SLOT_FIRST;
                        committed = pos_cnt;
                    end else begin
                        ph = PH_STOP;
                    end
                end
            end
        end
        if (is_last) begin
            any = 1'b0;
            total = 64'd0;
            for (int i = 0; i < 6; i++) begin
                if (comp[i] != 0) any = 1'b1;
                total += comp[i] * UNIT_SECS[i];
                if (total > SECONDS_CAP) total = SECONDS_CAP;
            end
            r.ok   = any && ph != PH_AWAIT_P && ph != PH_FAIL;
            r.clen = r.ok ? committed[7:0] : 8'd0;
            r.sat  = sat_flag;
            r.secs = r.ok ? total[41:0] : 42'd0;
            expected_durations.push_back(r);
            ph = PH_AWAIT_P;
            next_slot = SLOT_FIRST;
            digit_acc = 0;
            pend = 1'b0;
            pos_cnt = 0;
            committed = 0;
            foreach (comp[k]) comp[k] = 0;
            sat_flag = 1'b0;
        end
    endtask

    // Token building
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endtask

    task automatic add_digits();
        int pick;
        int ndig;
        pick = $urandom_range(0, 9);
        ndig = (pick < 6) ? $urandom_range(1, 3) : (pick < 9) ? $urandom_range(4, 5)
                                                                : $urandom_range(6, 7);
        repeat (ndig) tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_group(input logic [7:0] letter);
        if ($urandom_range(0, 1)) begin
            add_digits();
            tok.push_back(letter);
        end
    endtask

    task automatic ship_token();
        for (int i = 0; i < tok.size(); i++)
            pending_chars.push_back('{tok[i], i == tok.size() - 1});
        tok.delete();
    endtask

    task automatic make_random_token();
        int kind;
        int idx;
        int target;
        bit tpart;
        kind = $urandom_range(0, 99);
        if (kind < 74) begin
            // well-formed duration, sometimes damaged
            tok.push_back(CH_P);
            add_group(CH_Y);
            add_group(CH_M);
            add_group(CH_D);
            if ($urandom_range(0, 2) != 0) begin
                tok.push_back(CH_T);
                add_group(CH_H);
                add_group(CH_M);
                add_group(CH_S);
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, tok.size() - 1);
                case ($urandom_range(0, 5))
                    0: add_digits();
                    1: tok[idx] = 8'($urandom_range(0, 255));
                    2: tok[idx] = tok[idx] | 8'h20;
                    3: tok.push_back(CH_T);
                    4: begin
                        add_digits();
                        tok.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        add_digits();
                        case ($urandom_range(0, 5))
                            0: tok.push_back(CH_Y);
                            1: tok.push_back(CH_M);
                            2: tok.push_back(CH_D);
                            3: tok.push_back(CH_H);
                            4: tok.push_back(CH_S);
                            default: tok.push_back(CH_T);
                        endcase
                    end
                endcase
            end
        end else if (kind < 95) begin
            // noise bytes, half of them behind a leading P
            if ($urandom_range(0, 1)) tok.push_back(CH_P);
            repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
        end else begin
            // long token around the length limit
            tpart = $urandom_range(0, 1);
            tok.push_back(CH_P);
            if (tpart) tok.push_back(CH_T);
            target = $urandom_range(248, 262);
            while (tok.size() < target) tok.push_back(CH_ZERO);
            tok.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            tok.push_back(tpart ? CH_H : CH_D);
            repeat ($urandom_range(0, 3)) tok.push_back(8'($urandom_range(0, 255)));
        end
        ship_token();
    endtask

    // Input side: new item at the falling edge once the previous one was taken
    always @(negedge aclk) begin
        char_item_t c;
        if (aresetn && (char_taken || !s_tvalid)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                c = pending_chars.pop_front();
                s_tdata  <= c.code;
                s_tlast  <= c.is_last;
                s_tvalid <= 1'b1;
                chars_sent++;
                if (chars_sent < quiet_from && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 5);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side back-pressure, in bursts, none near the end
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (chars_sent < quiet_from && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    // Handshakes at the rising edge: predict on input, compare on output
    always @(posedge aclk) begin
        duration_t want;
        char_taken = aresetn && s_tvalid && s_tready;
        if (char_taken) parse_char(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            tokens_done++;
            if (expected_durations.size() == 0) begin
                $error("unexpected result item, tdata %h", m_tdata);
                errors++;
            end else begin
                want = expected_durations.pop_front();
                if (m_tdata[0] !== want.ok) begin
                    $error("accepted: expected %0d, got %0d", want.ok, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[8:1] !== want.clen) begin
                    $error("consumed_length: expected %0d, got %0d", want.clen, m_tdata[8:1]);
                    errors++;
                end
                if (m_tdata[9] !== want.sat) begin
                    $error("component_saturated: expected %0d, got %0d", want.sat, m_tdata[9]);
                    errors++;
                end
                if (m_tdata[51:10] !== want.secs) begin
                    $error("duration_seconds: expected %0d, got %0d", want.secs,
                           m_tdata[51:10]);
                    errors++;
                end
                if (want.ok) accepted_seen++;
                if (want.sat) saturated_seen++;
            end
        end
    end

    initial begin
        int total_chars;
        // directed tokens: extremes and each rejection path
        add_text("P1Y");                       ship_token();
        add_text("P1Y2M3DT4H5M6S");            ship_token();
        add_text("P65535Y65535M65535DT65535H65535M65535S"); ship_token();
        add_text("P");                         ship_token();
        add_text("PT");                        ship_token();
        add_text("P0D");                       ship_token();
        add_text("PT0S");                      ship_token();
        add_text("X5D");                       ship_token();
        add_text("p1D");                       ship_token();
        add_text("P1d");                       ship_token();
        add_text("P99999D");                   ship_token();
        add_text("P2M99999");                  ship_token();
        add_text("P1D1Y");                     ship_token();
        add_text("PT1S1H");                    ship_token();
        add_text("P7");                        ship_token();
        add_text("P1TT");                      ship_token();
        add_text("PTT1H");                     ship_token();
        add_text("P3W");                       ship_token();
        tok.push_back(8'hFF);                  ship_token();
        tok.push_back(8'h00);                  ship_token();
        // group closing exactly at the length limit, then a group past it
        add_text("PT");
        repeat (251) tok.push_back(CH_ZERO);
        add_text("1H5M");                      ship_token();

        while (pending_chars.size() < NUM_CHARS) make_random_token();
        total_chars = pending_chars.size();
        quiet_from = total_chars * 85 / 100;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_chars.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_durations.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_durations.size() > 0) begin
            $error("%0d results never arrived", expected_durations.size());
            errors++;
        end

        $display("Run covered %0d characters in %0d tokens: %0d accepted, %0d saturated.",
                 total_chars, tokens_done, accepted_seen, saturated_seen);
        $display("Errors logged: %0d", errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop if the stream hangs
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/idts_pkg.sv
rtl/idts_front.sv
rtl/idts_fifo.sv
rtl/idts_back.sv
rtl/iso8601_duration_to_seconds.sv
sim/tb_iso8601_duration_to_seconds.sv
